// ===== design/tdbq_pkg.sv =====
`default_nettype none

package tdbq_pkg;

    // sample and coefficient formats
    localparam int SAMPLE_W   = 24;
    localparam int FRAC       = SAMPLE_W - 1;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 11;
    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = 28;
    localparam int STATE_W    = 32;

    // soft clip table over magnitudes 0 to 8
    localparam int TANH_DEPTH = 256;
    localparam int TAB_IDX_W  = $clog2(TANH_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_GAIN = 3'd0,
        CFG_COEF_B0    = 3'd1,
        CFG_COEF_B1    = 3'd2,
        CFG_COEF_A1    = 3'd3,
        CFG_COEF_A2    = 3'd4,
        CFG_CHANNELS   = 3'd5
    } t_cfg_idx;

    // channel modes, also used as the active channel count
    localparam logic [1:0] CH_PASS   = 2'd0;
    localparam logic [1:0] CH_MONO   = 2'd1;
    localparam logic [1:0] CH_STEREO = 2'd2;

    typedef struct packed {
        logic        [GAIN_W-1:0] drive_gain;
        logic signed [COEF_W-1:0] coef_b0;
        logic signed [COEF_W-1:0] coef_b1;
        logic signed [COEF_W-1:0] coef_a1;
        logic signed [COEF_W-1:0] coef_a2;
        logic        [1:0]        channels_in_use;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } t_frame_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       clipped;
    } t_frame_out;

    // datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_IN,
        OP_DRIVE,
        OP_CLIP,
        OP_TAB0,
        OP_TAB1,
        OP_MUL_DIFF,
        OP_SHAPE,
        OP_MUL_B0,
        OP_SUM_Y,
        OP_MUL_A1,
        OP_UPD1,
        OP_UPD2,
        OP_LOAD_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic       right;
        logic [1:0] active;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== design/tdbq_cfg.sv =====
`default_nettype none

module tdbq_cfg import tdbq_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_index,
    input  wire logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // register file is always free to take a word
    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_gain      <= GAIN_W'(2048);
            r_cfg.coef_b0         <= COEF_W'(268435456);
            r_cfg.coef_b1         <= '0;
            r_cfg.coef_a1         <= '0;
            r_cfg.coef_a2         <= '0;
            r_cfg.channels_in_use <= CH_STEREO;
        end else if (i_valid) begin
            case (t_cfg_idx'(i_index))
                CFG_DRIVE_GAIN: r_cfg.drive_gain      <= i_data[GAIN_W-1:0];
                CFG_COEF_B0:    r_cfg.coef_b0         <= i_data[COEF_W-1:0];
                CFG_COEF_B1:    r_cfg.coef_b1         <= i_data[COEF_W-1:0];
                CFG_COEF_A1:    r_cfg.coef_a1         <= i_data[COEF_W-1:0];
                CFG_COEF_A2:    r_cfg.coef_a2         <= i_data[COEF_W-1:0];
                CFG_CHANNELS:   r_cfg.channels_in_use <= i_data[1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/tdbq_ctrl.sv =====
`default_nettype none

module tdbq_ctrl import tdbq_pkg::*; #(
    parameter int NUM_CHANNELS = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_channels,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRIVE,
        S_CLIP,
        S_TAB0,
        S_TAB1,
        S_MDIFF,
        S_SHAPE,
        S_MB0,
        S_SUMY,
        S_MA1,
        S_UPD1,
        S_UPD2,
        S_FINISH
    } t_state;

    t_state     r_state;
    logic       r_right;
    logic       r_out_valid;
    logic [1:0] r_active;
    logic [1:0] w_active;
    logic       w_out_free;

    // active channel count, value three counts as stereo; stereo falls back to mono with one channel slot
    always_comb begin
        case (i_channels)
            CH_PASS: w_active = CH_PASS;
            CH_MONO: w_active = CH_MONO;
            default: w_active = (NUM_CHANNELS > 1) ? CH_STEREO : CH_MONO;
        endcase
    end

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // sequencer, one datapath step per state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_right     <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= CH_PASS;
        end else begin
            // output word held until taken, refilled from the last step
            if (r_state == S_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_active <= w_active;
                        r_right  <= 1'b0;
                        r_state  <= (w_active == CH_PASS) ? S_FINISH : S_DRIVE;
                    end
                end
                S_DRIVE: r_state <= S_CLIP;
                S_CLIP:  r_state <= S_TAB0;
                S_TAB0:  r_state <= S_TAB1;
                S_TAB1:  r_state <= S_MDIFF;
                S_MDIFF: r_state <= S_SHAPE;
                S_SHAPE: r_state <= S_MB0;
                S_MB0:   r_state <= S_SUMY;
                S_SUMY:  r_state <= S_MA1;
                S_MA1:   r_state <= S_UPD1;
                S_UPD1:  r_state <= S_UPD2;
                S_UPD2: begin
                    if (!r_right && r_active == CH_STEREO) begin
                        r_right <= 1'b1;
                        r_state <= S_DRIVE;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // command decode
    always_comb begin
        o_cmd.right  = r_right;
        o_cmd.active = r_active;
        case (r_state)
            S_IDLE:   o_cmd.op = i_in_valid ? OP_LOAD_IN : OP_NONE;
            S_DRIVE:  o_cmd.op = OP_DRIVE;
            S_CLIP:   o_cmd.op = OP_CLIP;
            S_TAB0:   o_cmd.op = OP_TAB0;
            S_TAB1:   o_cmd.op = OP_TAB1;
            S_MDIFF:  o_cmd.op = OP_MUL_DIFF;
            S_SHAPE:  o_cmd.op = OP_SHAPE;
            S_MB0:    o_cmd.op = OP_MUL_B0;
            S_SUMY:   o_cmd.op = OP_SUM_Y;
            S_MA1:    o_cmd.op = OP_MUL_A1;
            S_UPD1:   o_cmd.op = OP_UPD1;
            S_UPD2:   o_cmd.op = OP_UPD2;
            S_FINISH: o_cmd.op = w_out_free ? OP_LOAD_OUT : OP_NONE;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/tdbq_dp.sv =====
`default_nettype none

module tdbq_dp import tdbq_pkg::*; #(
    parameter int NUM_CHANNELS = 2
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_dp_cmd   i_cmd,
    input  wire t_cfg      i_cfg,
    input  wire t_frame_in i_in_data,
    output t_frame_out     o_out_data
);

    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int D_W        = SAMPLE_W + GAIN_W - GAIN_FRAC;
    localparam int FR_W       = FRAC + 3;
    localparam int P_W        = FR_W + TAB_IDX_W;
    localparam int BX_W       = COEF_W + SAMPLE_W - COEF_FRAC;
    localparam int Y_W        = STATE_W + 1;
    localparam int FB_W       = PROD_W - COEF_FRAC;
    localparam int N_W        = FB_W + 1;
    localparam int RIGHT_SLOT = NUM_CHANNELS - 1;

    localparam longint Q30  = longint'(1) <<< 30;
    localparam longint SMAX = (longint'(1) <<< FRAC) - 1;

    localparam logic [D_W-1:0]       BIG_LIMIT = D_W'(1) << FR_W;
    localparam logic signed [N_W-1:0] ST_HI = N_W'({1'b0, {(STATE_W-1){1'b1}}});
    localparam logic signed [N_W-1:0] ST_LO = ~ST_HI;
    localparam logic signed [N_W-1:0] SM_HI = N_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
    localparam logic signed [N_W-1:0] SM_LO = ~SM_HI;

    // quotient of two non-negative values by shift and subtract
    function automatic longint div_pos(input longint num, input longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--) begin
            r = (r <<< 1) | ((num >>> b) & longint'(1));
            if (r >= den) begin
                r = r - den;
                q = q | (longint'(1) <<< b);
            end
        end
        return q;
    endfunction

    // exp(-f) for f in [0, 1] as a Q30 series
    function automatic longint exp_neg(input longint f);
        longint sum;
        longint term;
        sum  = Q30;
        term = Q30;
        for (int k = 1; k <= 24; k++) begin
            term = div_pos((term * f) >>> 30, longint'(k));
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > Q30) begin
            sum = Q30;
        end
        return sum;
    endfunction

    // tanh(8 i / depth) scaled to the sample range
    function automatic longint tanh_entry(input longint i);
        longint e1;
        longint num;
        longint n;
        longint rem;
        longint u;
        longint den;
        longint t;
        e1  = exp_neg(Q30);
        num = 16 * i;
        n   = num / TANH_DEPTH;
        rem = num % TANH_DEPTH;
        u   = exp_neg((rem <<< 30) / TANH_DEPTH);
        for (longint j = 0; j < n; j++) begin
            u = (u * e1) >>> 30;
        end
        den = Q30 + u;
        t   = div_pos(((Q30 - u) <<< FRAC) + den / 2, den);
        if (t < 0) begin
            t = 0;
        end
        if (t > SMAX) begin
            t = SMAX;
        end
        return t;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [N_W-1:0] v);
        logic signed [STATE_W-1:0] s;
        if (v > ST_HI) begin
            s = ST_HI[STATE_W-1:0];
        end else if (v < ST_LO) begin
            s = ST_LO[STATE_W-1:0];
        end else begin
            s = v[STATE_W-1:0];
        end
        return s;
    endfunction

    // soft clip table
    logic [SAMPLE_W-1:0] w_tab [TANH_DEPTH+1];

    for (genvar g = 0; g <= TANH_DEPTH; g++) begin : g_tab
        localparam logic [SAMPLE_W-1:0] ENTRY = SAMPLE_W'(tanh_entry(longint'(g)));
        assign w_tab[g] = ENTRY;
    end

    t_frame_in                  r_in;
    t_frame_out                 r_out;
    logic signed [PROD_W-1:0]   r_prod;
    logic [TAB_IDX_W-1:0]       r_idx;
    logic [FR_W-1:0]            r_fr;
    logic                       r_neg;
    logic [SAMPLE_W-1:0]        r_t0;
    logic [SAMPLE_W-1:0]        r_t1;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [BX_W-1:0]     r_bx;
    logic signed [Y_W-1:0]      r_y;
    logic signed [STATE_W-1:0]  r_yf;
    logic signed [Y_W-1:0]      r_acc;
    logic signed [SAMPLE_W-1:0] r_yl;
    logic signed [SAMPLE_W-1:0] r_yr;
    logic                       r_clip;
    logic signed [STATE_W-1:0]  r_fd [NUM_CHANNELS];
    logic signed [STATE_W-1:0]  r_sd [NUM_CHANNELS];

    logic signed [SAMPLE_W-1:0] w_sample;
    logic signed [MUL_W-1:0]    w_ma;
    logic signed [MUL_W-1:0]    w_mb;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [D_W-1:0]      w_drive;
    logic [D_W-1:0]             w_mag;
    logic                       w_big;
    logic [P_W-1:0]             w_pos;
    logic [TAB_IDX_W-1:0]       w_idx1;
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [SAMPLE_W:0]   w_interp;
    logic signed [SAMPLE_W:0]   w_shape;
    logic signed [SAMPLE_W:0]   w_x;
    logic signed [BX_W-1:0]     w_bx;
    logic signed [FB_W-1:0]     w_fb;
    logic signed [STATE_W-1:0]  w_fd_sel;
    logic signed [STATE_W-1:0]  w_sd_sel;
    logic signed [N_W-1:0]      w_y_wide;
    logic signed [STATE_W-1:0]  w_yf;
    logic signed [SAMPLE_W-1:0] w_ysat;
    logic                       w_yclip;
    logic signed [N_W-1:0]      w_n1;
    logic signed [N_W-1:0]      w_n2;

    assign w_sample = i_cmd.right ? r_in.right_in : r_in.left_in;
    assign w_fd_sel = i_cmd.right ? r_fd[RIGHT_SLOT] : r_fd[0];
    assign w_sd_sel = i_cmd.right ? r_sd[RIGHT_SLOT] : r_sd[0];

    // driven sample, magnitude and table position
    assign w_drive = r_prod[GAIN_FRAC+D_W-1:GAIN_FRAC];
    assign w_mag   = w_drive[D_W-1] ? D_W'(-w_drive) : D_W'(w_drive);
    assign w_big   = (w_mag >= BIG_LIMIT);
    assign w_pos   = P_W'(w_mag[FR_W-1:0]) * P_W'(TANH_DEPTH);
    assign w_idx1  = (r_idx == TAB_IDX_W'(TANH_DEPTH)) ? r_idx : r_idx + TAB_IDX_W'(1);

    // interpolation between neighbouring entries
    assign w_diff   = $signed({1'b0, r_t1}) - $signed({1'b0, r_t0});
    assign w_interp = r_prod[FR_W+SAMPLE_W:FR_W];
    assign w_shape  = $signed({1'b0, r_t0}) + w_interp;
    assign w_x      = r_neg ? -w_shape : w_shape;

    // filter products back to sample scale
    assign w_bx = r_prod[COEF_FRAC+BX_W-1:COEF_FRAC];
    assign w_fb = r_prod[PROD_W-1:COEF_FRAC];

    // output saturation and feedback word
    assign w_y_wide = N_W'(r_y);
    assign w_yf     = sat_state(w_y_wide);
    assign w_yclip  = (w_y_wide > SM_HI) || (w_y_wide < SM_LO);
    assign w_ysat   = (w_y_wide > SM_HI) ? SM_HI[SAMPLE_W-1:0] :
                      (w_y_wide < SM_LO) ? SM_LO[SAMPLE_W-1:0] : w_y_wide[SAMPLE_W-1:0];

    assign w_n1 = N_W'(r_acc) - N_W'(w_fb);
    assign w_n2 = N_W'(r_bx) - N_W'(w_fb);

    // shared multiplier operand selection
    always_comb begin
        case (i_cmd.op)
            OP_DRIVE: begin
                w_ma = MUL_W'(w_sample);
                w_mb = $signed(MUL_W'(i_cfg.drive_gain));
            end
            OP_MUL_DIFF: begin
                w_ma = MUL_W'(w_diff);
                w_mb = $signed(MUL_W'(r_fr));
            end
            OP_MUL_B0: begin
                w_ma = i_cfg.coef_b0;
                w_mb = MUL_W'(r_x);
            end
            OP_SUM_Y: begin
                w_ma = i_cfg.coef_b1;
                w_mb = MUL_W'(r_x);
            end
            OP_MUL_A1: begin
                w_ma = i_cfg.coef_a1;
                w_mb = MUL_W'(w_yf);
            end
            OP_UPD1: begin
                w_ma = i_cfg.coef_a2;
                w_mb = MUL_W'(r_yf);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_ma) * PROD_W'(w_mb);

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD_IN: begin
                r_in   <= i_in_data;
                r_clip <= 1'b0;
            end
            OP_DRIVE: r_prod <= w_prod;
            OP_CLIP: begin
                r_neg <= w_drive[D_W-1];
                if (w_big) begin
                    r_idx <= TAB_IDX_W'(TANH_DEPTH);
                    r_fr  <= '0;
                end else begin
                    r_idx <= w_pos[P_W-1:FR_W];
                    r_fr  <= w_pos[FR_W-1:0];
                end
            end
            OP_TAB0:     r_t0 <= w_tab[r_idx];
            OP_TAB1:     r_t1 <= w_tab[w_idx1];
            OP_MUL_DIFF: r_prod <= w_prod;
            OP_SHAPE:    r_x <= w_x[SAMPLE_W-1:0];
            OP_MUL_B0:   r_prod <= w_prod;
            OP_SUM_Y: begin
                r_bx   <= w_bx;
                r_y    <= Y_W'(w_bx) + Y_W'(w_fd_sel);
                r_prod <= w_prod;
            end
            OP_MUL_A1: begin
                r_acc  <= Y_W'(w_bx) + Y_W'(w_sd_sel);
                r_yf   <= w_yf;
                r_prod <= w_prod;
                r_clip <= r_clip | w_yclip;
                if (i_cmd.right) begin
                    r_yr <= w_ysat;
                end else begin
                    r_yl <= w_ysat;
                end
            end
            OP_UPD1: r_prod <= w_prod;
            OP_LOAD_OUT: begin
                r_out.clipped <= r_clip;
                case (i_cmd.active)
                    CH_PASS: begin
                        r_out.left_out  <= r_in.left_in;
                        r_out.right_out <= r_in.right_in;
                    end
                    CH_MONO: begin
                        r_out.left_out  <= r_yl;
                        r_out.right_out <= r_yl;
                    end
                    default: begin
                        r_out.left_out  <= r_yl;
                        r_out.right_out <= r_yr;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // per channel delay words
    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_slot
        logic w_hit;
        assign w_hit = i_cmd.right ? (g == RIGHT_SLOT) : (g == 0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fd[g] <= '0;
                r_sd[g] <= '0;
            end else begin
                if (w_hit && i_cmd.op == OP_UPD1) begin
                    r_fd[g] <= sat_state(w_n1);
                end
                if (w_hit && i_cmd.op == OP_UPD2) begin
                    r_sd[g] <= sat_state(w_n2);
                end
            end
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

// ===== design/tanh_drive_biquad_lowpass.sv =====
`default_nettype none

// Drive, tanh soft clip and biquad low-pass on one stereo frame per word.
// Each active channel is scaled by the drive gain, shaped by an interpolated
// tanh table and filtered by a transposed direct form II biquad; the output
// saturates to the sample range and clipped flags any saturation. All
// channels share one 32x32 multiplier, and the table is read twice per
// channel, so a channel takes 11 steps. After the last channel's steps, or
// straight from acceptance in pass-through, a finish step loads the result
// register; the next frame is taken in the cycle after it at the earliest.
// The input is taken again while a result waits in the output register; a
// stalled receiver holds the next result in its last step. No clearing pass
// follows reset. Configuration is written through its own port; the user
// must write it only while no frame is in flight, as the block itself does
// not enforce this.
module tanh_drive_biquad_lowpass import tdbq_pkg::*; #(
    parameter int NUM_CHANNELS = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_frame_in             i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_frame_out                 o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;

    // configuration registers
    tdbq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // step sequencer and handshakes
    tdbq_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_channels  (w_cfg.channels_in_use),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // shaping and filter arithmetic
    tdbq_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg      (w_cfg),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire
